// File: hdl/lmls_pkg.sv
// Shared types, register codes and helpers for the lamp mode and level selector.
package lmls_pkg;

  // Register indexes on the configuration port (byte address is 4 * index).
  typedef enum logic [2:0] {
    REG_NIGHT_THRESHOLD  = 3'd0,
    REG_NIGHT_HYSTERESIS = 3'd1,
    REG_WHITE_LEVEL_A    = 3'd2,
    REG_RED_LEVEL_A      = 3'd3,
    REG_IR_LEVEL_A       = 3'd4,
    REG_WHITE_LEVEL_B    = 3'd5,
    REG_RED_LEVEL_B      = 3'd6,
    REG_IR_LEVEL_B       = 3'd7
  } lmls_reg_t;

  localparam int unsigned CFG_ADDR_W  = 5;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 88;

  // DIP switch bit positions
  localparam int unsigned DIP_VISUAL    = 0;
  localparam int unsigned DIP_PHOTO     = 1;
  localparam int unsigned DIP_NIGHT_SEL = 2;

  // Level shown in the level word while the emergency key is pressed
  localparam logic [3:0] EMERGENCY_LEVEL = 4'd7;

  typedef struct packed {
    logic [15:0] night_threshold;
    logic [15:0] night_hysteresis;
    logic [7:0]  white_level_a;
    logic [7:0]  red_level_a;
    logic [7:0]  ir_level_a;
    logic [7:0]  white_level_b;
    logic [7:0]  red_level_b;
    logic [7:0]  ir_level_b;
  } lmls_cfg_t;

  typedef struct packed {
    logic [4:0]  dip_switch;
    logic [3:0]  encoder_code;
    logic [15:0] remote_value;
    logic [15:0] light_level;
    logic        emergency_key;
  } lmls_item_t;

  typedef struct packed {
    logic [15:0] pwm_white;
    logic [15:0] pwm_ir_one;
    logic [15:0] pwm_red;
    logic [15:0] pwm_ir_two;
    logic [15:0] level_word;
    logic        night_now;
    logic        night_toggled;
    logic        remote_changed;
  } lmls_result_t;

  // Times ten as two shifts and one add; 8-bit level fits in 12 bits.
  function automatic logic [15:0] times_ten(input logic [7:0] lvl);
    logic [11:0] by8;
    logic [11:0] by2;
    by8 = {1'b0, lvl, 3'b000};
    by2 = {3'b000, lvl, 1'b0};
    return {4'b0000, by8 + by2};
  endfunction

endpackage

// File: hdl/lmls_cfg_regs.sv
// Configuration register bank behind the APB-style port.
module lmls_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lmls_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [lmls_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lmls_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output lmls_pkg::lmls_cfg_t               cfg
);

  lmls_pkg::lmls_cfg_t cfg_r;
  lmls_pkg::lmls_cfg_t cfg_nxt;
  lmls_pkg::lmls_reg_t reg_idx;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_idx = lmls_pkg::lmls_reg_t'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        lmls_pkg::REG_NIGHT_THRESHOLD:  cfg_nxt.night_threshold  = pwdata[15:0];
        lmls_pkg::REG_NIGHT_HYSTERESIS: cfg_nxt.night_hysteresis = pwdata[15:0];
        lmls_pkg::REG_WHITE_LEVEL_A:    cfg_nxt.white_level_a    = pwdata[7:0];
        lmls_pkg::REG_RED_LEVEL_A:      cfg_nxt.red_level_a      = pwdata[7:0];
        lmls_pkg::REG_IR_LEVEL_A:       cfg_nxt.ir_level_a       = pwdata[7:0];
        lmls_pkg::REG_WHITE_LEVEL_B:    cfg_nxt.white_level_b    = pwdata[7:0];
        lmls_pkg::REG_RED_LEVEL_B:      cfg_nxt.red_level_b      = pwdata[7:0];
        lmls_pkg::REG_IR_LEVEL_B:       cfg_nxt.ir_level_b       = pwdata[7:0];
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lmls_pkg::REG_NIGHT_THRESHOLD:  prdata = {16'd0, cfg_r.night_threshold};
      lmls_pkg::REG_NIGHT_HYSTERESIS: prdata = {16'd0, cfg_r.night_hysteresis};
      lmls_pkg::REG_WHITE_LEVEL_A:    prdata = {24'd0, cfg_r.white_level_a};
      lmls_pkg::REG_RED_LEVEL_A:      prdata = {24'd0, cfg_r.red_level_a};
      lmls_pkg::REG_IR_LEVEL_A:       prdata = {24'd0, cfg_r.ir_level_a};
      lmls_pkg::REG_WHITE_LEVEL_B:    prdata = {24'd0, cfg_r.white_level_b};
      lmls_pkg::REG_RED_LEVEL_B:      prdata = {24'd0, cfg_r.red_level_b};
      lmls_pkg::REG_IR_LEVEL_B:       prdata = {24'd0, cfg_r.ir_level_b};
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hdl/lmls_in_stage.sv
// Input register stage: capture one sample transaction per cycle unless the held sample is stalled.
module lmls_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lmls_pkg::lmls_item_t in_item,
  output logic                 s1_valid,
  output lmls_pkg::lmls_item_t s1_item,
  input  logic                 s1_take
);

  logic                 valid_r;
  logic                 valid_nxt;
  lmls_pkg::lmls_item_t item_r;

  // Accept whenever the held sample leaves this cycle or none is held.
  assign in_ready  = !valid_r || s1_take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !s1_take);
  assign s1_valid  = valid_r;
  assign s1_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// File: hdl/lmls_core.sv
// Level selection, day/night update and result register.
module lmls_core #(
  parameter logic [3:0] REMOTE_CODE = 4'd0,
  parameter logic [3:0] AUTO_CODE   = 4'd1,
  parameter logic [3:0] OFF_CODE    = 4'd2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lmls_pkg::lmls_cfg_t    cfg,
  input  logic                   s1_valid,
  input  lmls_pkg::lmls_item_t   s1_item,
  output logic                   s1_take,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lmls_pkg::lmls_result_t out_result
);

  logic [3:0]             level_r, level_nxt;
  logic                   night_r, night_nxt;
  logic [15:0]            remote_r;
  logic                   out_valid_r, out_valid_nxt;
  lmls_pkg::lmls_result_t result_r, result_nxt;

  logic        load;
  logic        visual, photo, night_sel;
  logic        is_auto, is_remote;
  logic [16:0] day_limit;
  logic [15:0] drv_w, drv_r, drv_ir;
  logic [3:0]  lev;

  assign s1_take       = !out_valid_r || out_ready;
  assign load          = s1_valid && s1_take;
  assign out_valid_nxt = s1_valid || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;
  assign out_result    = result_r;

  assign visual    = s1_item.dip_switch[lmls_pkg::DIP_VISUAL];
  assign photo     = s1_item.dip_switch[lmls_pkg::DIP_PHOTO];
  assign night_sel = s1_item.dip_switch[lmls_pkg::DIP_NIGHT_SEL];
  assign is_auto   = (s1_item.encoder_code == AUTO_CODE);
  assign is_remote = (s1_item.encoder_code == REMOTE_CODE);
  assign day_limit = {1'b0, cfg.night_threshold} + {1'b0, cfg.night_hysteresis};

  always_comb begin
    level_nxt = level_r;
    if (s1_item.encoder_code >= OFF_CODE) begin
      level_nxt = s1_item.encoder_code - OFF_CODE;
    end

    if (!night_r) begin
      night_nxt = (s1_item.light_level < cfg.night_threshold);
    end else begin
      night_nxt = !({1'b0, s1_item.light_level} > day_limit);
    end

    drv_w  = '0;
    drv_r  = '0;
    drv_ir = '0;
    if (is_auto) begin
      if (photo && night_nxt) begin
        if (night_sel) begin
          drv_w  = lmls_pkg::times_ten(cfg.white_level_a);
          drv_r  = lmls_pkg::times_ten(cfg.red_level_a);
          drv_ir = lmls_pkg::times_ten(cfg.ir_level_a);
        end else begin
          drv_w  = lmls_pkg::times_ten(cfg.white_level_b);
          drv_r  = lmls_pkg::times_ten(cfg.red_level_b);
          drv_ir = lmls_pkg::times_ten(cfg.ir_level_b);
        end
      end
    end else if (is_remote) begin
      drv_w  = s1_item.remote_value;
      drv_r  = s1_item.remote_value;
      drv_ir = s1_item.remote_value;
    end

    lev = s1_item.emergency_key ? lmls_pkg::EMERGENCY_LEVEL : level_nxt;

    if (visual) begin
      result_nxt.pwm_white  = drv_w;
      result_nxt.pwm_ir_one = '0;
      result_nxt.pwm_red    = drv_r;
      result_nxt.pwm_ir_two = '0;
      result_nxt.level_word = {4'd0, lev, 4'd0, lev};
    end else begin
      result_nxt.pwm_white  = '0;
      result_nxt.pwm_ir_one = drv_ir;
      result_nxt.pwm_red    = '0;
      result_nxt.pwm_ir_two = drv_ir;
      result_nxt.level_word = {lev, 4'd0, lev, 4'd0};
    end
    result_nxt.night_now      = night_nxt;
    result_nxt.night_toggled  = (night_nxt != night_r);
    result_nxt.remote_changed = (s1_item.remote_value != remote_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      night_r     <= 1'b0;
      remote_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        level_r  <= level_nxt;
        night_r  <= night_nxt;
        remote_r <= s1_item.remote_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A loaded sample shows up as a valid result on the next cycle.
  a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("loaded sample did not produce a result");

  // The reported flag is the flag now held as state.
  a_night_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (result_r.night_now == night_r))
    else $error("night_now disagrees with stored flag");

  // The toggle mark agrees with the change of the stored flag.
  a_toggle_matches_change: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (result_r.night_toggled == (night_r != $past(night_r))))
    else $error("night_toggled disagrees with flag change");

  // Visual and IR channels are never driven together.
  a_routing_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((result_r.pwm_white == 16'd0 && result_r.pwm_red == 16'd0) ||
                     (result_r.pwm_ir_one == 16'd0 && result_r.pwm_ir_two == 16'd0)))
    else $error("visual and IR drives both active");
`endif

endmodule

// File: hdl/lamp_mode_level_selector_unit.sv
// Top level of the lamp mode and level selector.
//
//  channel  direction  width  handshake               carries
//  in_*     input      48     tvalid/tready           one panel sample
//  out_*    output     88     tvalid/tready           drives, level word, flags
//  APB      input      32     psel/penable/pready     eight config registers
//
// Flow: a sample accepted into the input register is processed from there and
// lands in the result register, raising out_tvalid, once the output slot is
// free; a new sample can be taken every cycle while out_tready keeps up.
// Reset: synchronous, active low; clears config registers, encoder level,
// day/night flag, stored remote value and both valid bits.
// Stalls: in_tready drops only when the input register holds a sample and the
// result register is full and not being taken.
module lamp_mode_level_selector_unit #(
  parameter logic [3:0] REMOTE_CODE = 4'd0,
  parameter logic [3:0] AUTO_CODE   = 4'd1,
  parameter logic [3:0] OFF_CODE    = 4'd2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input sample stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // from bit 0: dip_switch[4:0], encoder_code[8:5], remote_value[24:9],
  // light_level[40:25], emergency_key[41], zero fill [47:42]
  input  logic [lmls_pkg::IN_TDATA_W-1:0]     in_tdata,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // from bit 0: pwm_white[15:0], pwm_ir_one[31:16], pwm_red[47:32],
  // pwm_ir_two[63:48], level_word[79:64], night_now[80], night_toggled[81],
  // remote_changed[82], zero fill [87:83]
  output logic [lmls_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lmls_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [lmls_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [lmls_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  lmls_pkg::lmls_cfg_t    cfg;
  lmls_pkg::lmls_item_t   in_item;
  lmls_pkg::lmls_item_t   s1_item;
  lmls_pkg::lmls_result_t result;
  logic                   s1_valid;
  logic                   s1_take;

  // Unpack the sample transaction.
  assign in_item.dip_switch    = in_tdata[4:0];
  assign in_item.encoder_code  = in_tdata[8:5];
  assign in_item.remote_value  = in_tdata[24:9];
  assign in_item.light_level   = in_tdata[40:25];
  assign in_item.emergency_key = in_tdata[41];

  // Pack the result transaction; high bits stay zero.
  assign out_tdata = {5'd0,
                      result.remote_changed,
                      result.night_toggled,
                      result.night_now,
                      result.level_word,
                      result.pwm_ir_two,
                      result.pwm_red,
                      result.pwm_ir_one,
                      result.pwm_white};

  lmls_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Hold one sample ahead of the processing logic.
  lmls_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take)
  );

  // Advance state and register the result when the output slot is free.
  lmls_core #(
    .REMOTE_CODE (REMOTE_CODE),
    .AUTO_CODE   (AUTO_CODE),
    .OFF_CODE    (OFF_CODE)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item),
    .s1_take    (s1_take),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

endmodule
